// ----- design/sgdmf_pkg.sv -----
// ----------------------------------------------------------------------------
// sgdmf_pkg
// Shared types, constants and arithmetic helpers for the SGD factor block.
// ----------------------------------------------------------------------------
`default_nettype none

package sgdmf_pkg;

    localparam int MAX_USERS    = 1024;
    localparam int MAX_MOVIES   = 1024;
    localparam int MAX_FEATURES = 16;

    localparam int USER_AW = $clog2(MAX_USERS);
    localparam int MOVIE_AW = $clog2(MAX_MOVIES);
    localparam int FEAT_W  = $clog2(MAX_FEATURES);
    localparam int CNT_W   = $clog2(MAX_FEATURES + 1);
    localparam int ACC_W   = 52;

    localparam int CFG_W   = 24;
    localparam int CFG_AW  = 2;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_USER_REG      = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MOVIE_REG     = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_FEATURE_COUNT = 2'd3;

    localparam logic [23:0] RST_LEARNING_RATE = 24'd1678;
    localparam logic [23:0] RST_REG           = 24'd16777;
    localparam logic [4:0]  RST_FEATURE_COUNT = 5'd10;

    localparam logic [2:0] K_WR_USER  = 3'd0;
    localparam logic [2:0] K_WR_MOVIE = 3'd1;
    localparam logic [2:0] K_TRAIN    = 3'd2;
    localparam logic [2:0] K_RD_USER  = 3'd3;
    localparam logic [2:0] K_RD_MOVIE = 3'd4;
    localparam logic [2:0] K_PREDICT  = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [9:0]         user_index;
        logic [9:0]         movie_index;
        logic [3:0]         feature_index;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] data_value;
        logic signed [31:0] error_value;
        logic [31:0]        squared_error;
        logic               skipped;
    } t_result;

    typedef enum logic [2:0] {
        MS_UM = 3'd0,   // user x movie (dot product term)
        MS_EE = 3'd1,   // error squared
        MS_EP = 3'd2,   // error x partner element
        MS_LX = 3'd3,   // lambda x own element
        MS_TR = 3'd4    // step x learning rate
    } t_mul_sel;

    typedef enum logic [1:0] {
        OUT_ZERO = 2'd0,
        OUT_READ = 2'd1,
        OUT_SKIP = 2'd2,
        OUT_PRED = 2'd3
    } t_out_sel;

    typedef struct packed {
        logic              load;
        logic              feat_fi;     // address by the item's feature index
        logic [FEAT_W-1:0] feat;
        logic              latch;
        logic              acc_clr;
        logic              acc_add;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic              side;        // 0 user vector, 1 movie vector
        logic              err_en;
        logic              a_en;
        logic              t_en;
        logic              new_en;
        logic              wr_item;
        logic              wr_upd;
        logic              out_en;
        t_out_sel          out_sel;
    } t_cmd;

    typedef struct packed {
        logic [2:0]       kind;
        logic             zero_rating;
        logic [CNT_W-1:0] nfeat;
    } t_stat;

    localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] I32_MIN = -64'sh0000_0000_8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > I32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < I32_MIN) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/sgdmf_ctrl.sv -----
// ----------------------------------------------------------------------------
// sgdmf_ctrl
// Sequencer: walks the datapath through access, dot product and update steps.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdmf_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  sgdmf_pkg::t_stat    i_stat,
    output sgdmf_pkg::t_cmd     o_cmd
);
    import sgdmf_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_DISP = 20'h00002,
        S_WR   = 20'h00004,
        S_RD   = 20'h00008,
        S_RDW  = 20'h00010,
        S_DRD  = 20'h00020,
        S_DLAT = 20'h00040,
        S_DMUL = 20'h00080,
        S_DACC = 20'h00100,
        S_ERR  = 20'h00200,
        S_SQM  = 20'h00400,
        S_SQ   = 20'h00800,
        S_URD  = 20'h01000,
        S_ULAT = 20'h02000,
        S_U1   = 20'h04000,
        S_U2   = 20'h08000,
        S_U3   = 20'h10000,
        S_U4   = 20'h20000,
        S_U5   = 20'h40000,
        S_UWR  = 20'h80000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_f, n_f;
    logic             r_side, n_side;
    logic [CNT_W-1:0] f_inc;

    assign f_inc = r_f + CNT_W'(1);
    assign busy  = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_f     <= '0;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_f     <= n_f;
            r_side  <= n_side;
        end
    end

    always_comb begin
        n_state = r_state;
        n_f     = r_f;
        n_side  = r_side;
        o_cmd   = '0;
        o_cmd.feat    = r_f[FEAT_W-1:0];
        o_cmd.side    = r_side;
        o_cmd.mul_sel = MS_UM;
        o_cmd.out_sel = OUT_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_f = '0;
                if (i_stat.kind == K_WR_USER || i_stat.kind == K_WR_MOVIE) begin
                    n_state = S_WR;
                end else if (i_stat.kind == K_RD_USER || i_stat.kind == K_RD_MOVIE) begin
                    n_state = S_RD;
                end else if (i_stat.kind == K_TRAIN || i_stat.kind == K_PREDICT) begin
                    if (i_stat.zero_rating) begin
                        o_cmd.out_en  = 1'b1;
                        o_cmd.out_sel = OUT_SKIP;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.acc_clr = 1'b1;
                        n_state = (i_stat.nfeat == '0) ? S_ERR : S_DRD;
                    end
                end else begin
                    // unused kind: empty answer
                    o_cmd.out_en = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WR: begin
                o_cmd.feat_fi = 1'b1;
                o_cmd.wr_item = 1'b1;
                o_cmd.out_en  = 1'b1;
                n_state       = S_IDLE;
            end
            S_RD: begin
                o_cmd.feat_fi = 1'b1;
                n_state       = S_RDW;
            end
            S_RDW: begin
                o_cmd.feat_fi = 1'b1;
                o_cmd.out_en  = 1'b1;
                o_cmd.out_sel = OUT_READ;
                n_state       = S_IDLE;
            end
            S_DRD: n_state = S_DLAT;
            S_DLAT: begin
                o_cmd.latch = 1'b1;
                n_state     = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_UM;
                n_state       = S_DACC;
            end
            S_DACC: begin
                o_cmd.acc_add = 1'b1;
                if (f_inc == i_stat.nfeat) begin
                    n_state = S_ERR;
                end else begin
                    n_f     = f_inc;
                    n_state = S_DRD;
                end
            end
            S_ERR: begin
                o_cmd.err_en = 1'b1;
                n_state      = S_SQM;
            end
            S_SQM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_EE;
                n_state       = S_SQ;
            end
            S_SQ: begin
                o_cmd.out_en  = 1'b1;
                o_cmd.out_sel = OUT_PRED;
                n_f           = '0;
                n_side        = 1'b0;
                if (i_stat.kind == K_TRAIN && i_stat.nfeat != '0) begin
                    n_state = S_URD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_URD: n_state = S_ULAT;
            S_ULAT: begin
                o_cmd.latch = 1'b1;
                n_state     = S_U1;
            end
            S_U1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_EP;
                n_state       = S_U2;
            end
            S_U2: begin
                o_cmd.a_en    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_LX;
                n_state       = S_U3;
            end
            S_U3: begin
                o_cmd.t_en = 1'b1;
                n_state    = S_U4;
            end
            S_U4: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_TR;
                n_state       = S_U5;
            end
            S_U5: begin
                o_cmd.new_en = 1'b1;
                if (r_side) begin
                    n_side  = 1'b0;
                    n_state = S_UWR;
                end else begin
                    n_side  = 1'b1;
                    n_state = S_U1;
                end
            end
            S_UWR: begin
                o_cmd.wr_upd = 1'b1;
                if (f_inc == i_stat.nfeat) begin
                    n_state = S_IDLE;
                end else begin
                    n_f     = f_inc;
                    n_state = S_URD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/sgdmf_dpath.sv -----
// ----------------------------------------------------------------------------
// sgdmf_dpath
// Factor tables, configuration, shared multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdmf_dpath (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  sgdmf_pkg::t_item          i_item,
    input  wire                       i_cfg_we,
    input  wire [sgdmf_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire [sgdmf_pkg::CFG_W-1:0]  i_cfg_data,
    input  sgdmf_pkg::t_cmd           i_cmd,
    output sgdmf_pkg::t_stat          o_stat,
    output sgdmf_pkg::t_result        o_result,
    output logic                      o_valid
);
    import sgdmf_pkg::*;

    localparam int UDEPTH = MAX_USERS * MAX_FEATURES;
    localparam int MDEPTH = MAX_MOVIES * MAX_FEATURES;

    logic [23:0] r_lr, r_lu, r_lm;
    logic [4:0]  r_fc;

    t_item r_item;

    logic signed [31:0] user_mem  [UDEPTH];
    logic signed [31:0] movie_mem [MDEPTH];
    logic signed [31:0] r_urd, r_mrd;

    logic signed [31:0] r_xu, r_xm, r_pred, r_err, r_t, r_nu, r_nm;
    logic signed [63:0] r_prod, r_a;
    logic signed [ACC_W-1:0] r_acc;

    t_result r_result;
    t_result n_result;
    logic    r_valid;

    logic [FEAT_W-1:0]          feat;
    logic [USER_AW+FEAT_W-1:0]  u_addr;
    logic [MOVIE_AW+FEAT_W-1:0] m_addr;
    logic                       u_we, m_we;
    logic signed [31:0]         u_wd, m_wd;
    logic signed [31:0]         op_a, op_b, x_sel;
    logic signed [63:0]         prod;
    logic signed [31:0]         pred_c;
    logic signed [63:0]         diff, sum;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= RST_LEARNING_RATE;
            r_lu <= RST_REG;
            r_lm <= RST_REG;
            r_fc <= RST_FEATURE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LEARNING_RATE: r_lr <= i_cfg_data;
                CFG_USER_REG:      r_lu <= i_cfg_data;
                CFG_MOVIE_REG:     r_lm <= i_cfg_data;
                CFG_FEATURE_COUNT: r_fc <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    assign o_stat.kind        = r_item.kind;
    assign o_stat.zero_rating = (r_item.value == '0);
    assign o_stat.nfeat = (CNT_W'(r_fc) > CNT_W'(MAX_FEATURES)) ? CNT_W'(MAX_FEATURES)
                                                               : CNT_W'(r_fc);

    // tables
    assign feat   = i_cmd.feat_fi ? r_item.feature_index[FEAT_W-1:0] : i_cmd.feat;
    assign u_addr = {r_item.user_index[USER_AW-1:0], feat};
    assign m_addr = {r_item.movie_index[MOVIE_AW-1:0], feat};
    assign u_we   = (i_cmd.wr_item && r_item.kind == K_WR_USER) || i_cmd.wr_upd;
    assign m_we   = (i_cmd.wr_item && r_item.kind == K_WR_MOVIE) || i_cmd.wr_upd;
    assign u_wd   = i_cmd.wr_upd ? r_nu : r_item.value;
    assign m_wd   = i_cmd.wr_upd ? r_nm : r_item.value;

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            user_mem[u_addr] <= u_wd;
        end
        r_urd <= user_mem[u_addr];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            movie_mem[m_addr] <= m_wd;
        end
        r_mrd <= movie_mem[m_addr];
    end

    // shared multiplier
    assign x_sel = i_cmd.side ? r_xm : r_xu;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_UM: begin op_a = r_xu;  op_b = r_xm; end
            MS_EE: begin op_a = r_err; op_b = r_err; end
            MS_EP: begin op_a = r_err; op_b = i_cmd.side ? r_xu : r_xm; end
            MS_LX: begin
                op_a = $signed({8'd0, (i_cmd.side ? r_lm : r_lu)});
                op_b = x_sel;
            end
            MS_TR: begin op_a = r_t;   op_b = $signed({8'd0, r_lr}); end
            default: begin op_a = '0;  op_b = '0; end
        endcase
    end

    assign prod   = op_a * op_b;
    assign pred_c = sat32(64'(r_acc));
    assign diff   = r_a - (r_prod >>> 8);
    assign sum    = 64'(x_sel) + (r_prod >>> 24);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_xu <= r_urd;
            r_xm <= r_mrd;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + ACC_W'(r_prod >>> 16);
        end
        if (i_cmd.err_en) begin
            r_pred <= pred_c;
            r_err  <= sat32(64'(r_item.value) - 64'(pred_c));
        end
        if (i_cmd.a_en) begin
            r_a <= r_prod;
        end
        if (i_cmd.t_en) begin
            r_t <= sat32(diff >>> 16);
        end
        if (i_cmd.new_en) begin
            if (i_cmd.side) begin
                r_nm <= sat32(sum);
            end else begin
                r_nu <= sat32(sum);
            end
        end
    end

    // result register; prediction fields take the squared error from the registered product r_prod
    always_comb begin
        n_result = '0;
        case (i_cmd.out_sel)
            OUT_READ: n_result.data_value = (r_item.kind == K_RD_USER) ? r_urd : r_mrd;
            OUT_SKIP: n_result.skipped = 1'b1;
            OUT_PRED: begin
                n_result.data_value    = r_pred;
                n_result.error_value   = r_err;
                n_result.squared_error = (|r_prod[63:48]) ? 32'hFFFF_FFFF
                                                          : r_prod[47:16];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_en;
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_valid;

endmodule

`default_nettype wire

// ----- design/sgd_matrix_factorization_step.sv -----
// ----------------------------------------------------------------------------
// sgd_matrix_factorization_step
// One SGD step of matrix factorization over on-chip user and movie tables.
// ----------------------------------------------------------------------------
// Usage: raise start with an item on i_item while busy is low; the beat is
// taken at that edge. Every item answers exactly one result, shown on
// o_result for a single cycle with o_valid high; there is no back-pressure,
// so the receiver must take it then. Items run one at a time through a
// sequencer and one shared 32x32 multiplier, with one read port per table.
// With n active features (feature_count, capped at 16), train and predict
// walk the features in turn for the dot product (read, latch, multiply,
// accumulate); train then walks them again for the update (read, latch,
// five steps for each vector, three of them on the multiplier, write-back).
// A zero rating skips train and predict. The train result comes out after
// the dot product, error and squared error, while the update still runs.
// Tables need no clearing pass; unwritten elements read as whatever the RAM
// holds. Configuration writes go on i_cfg_* only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_matrix_factorization_step (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  sgdmf_pkg::t_item            i_item,
    output sgdmf_pkg::t_result          o_result,
    output logic                        o_valid,
    input  wire                         i_cfg_we,
    input  wire [sgdmf_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire [sgdmf_pkg::CFG_W-1:0]  i_cfg_data
);
    import sgdmf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    sgdmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // tables, arithmetic and result beat
    sgdmf_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result),
        .o_valid    (o_valid)
    );

endmodule

`default_nettype wire
